[hdl/pwts_pkg.sv]
// shared types and constants for the perspective world-to-screen core
package pwts_pkg;

  // fixed datapath widths
  localparam int D_W    = 33;  // point minus camera, Q24.8
  localparam int C_W    = 18;  // axis coefficients, Q1.14 with headroom
  localparam int P_W    = D_W + C_W;  // one dot-product term
  localparam int ACC_W  = 54;  // dot-product sums, Q.22
  localparam int R10_W  = ACC_W - 12;  // right / up after dropping 12 bits
  localparam int DEP_W  = 41;  // positive depth, Q.10
  localparam int INV_W  = 23;
  localparam int M_W    = R10_W + INV_W + 1;  // scaled by inverse tangent
  localparam int RX_W   = M_W - 16;
  localparam int HS_W   = 19;  // signed viewport gain, up to 8192*16
  localparam int N_W    = RX_W + HS_W;  // dividend
  localparam int QB     = 26;  // quotient bits kept before saturation
  localparam int S_W    = QB + 2;  // offset plus quotient
  localparam int OUT_W  = 24;
  localparam int QUEUE_DEPTH = 8;
  localparam int QA_W   = 3;  // queue address bits
  localparam int QC_W   = 4;  // queue / credit count bits

  localparam logic signed [ACC_W-1:0] DEPTH_MIN = ACC_W'(4195);
  localparam logic signed [S_W-1:0] OUT_MAX = S_W'(8388607);
  localparam logic signed [S_W-1:0] OUT_MIN = -S_W'(8388608);

  // configuration register indexes
  typedef enum logic [3:0] {
    REG_CAM_X     = 4'd0,
    REG_CAM_Y     = 4'd1,
    REG_CAM_Z     = 4'd2,
    REG_SIN_PITCH = 4'd3,
    REG_COS_PITCH = 4'd4,
    REG_SIN_YAW   = 4'd5,
    REG_COS_YAW   = 4'd6,
    REG_INV_TAN   = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic              visible;
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
  } result_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [15:0] sin_pitch;
    logic signed [15:0] cos_pitch;
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_yaw;
    logic [INV_W-1:0]   inv_half_fov_tan;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               visible;
    logic [DEP_W-1:0]   depth10;
    logic signed [R10_W-1:0] right10;
    logic signed [R10_W-1:0] up10;
  } mid_t;

endpackage

[hdl/perspective_world_to_screen_core.sv]
// top level of the perspective world-to-screen core: registers and block wiring
//
//   channel   signals                         request
//   --------  ------------------------------  ------------------------------
//   point     push, full, point               one world point (x, y, z)
//   result    empty, pop, result              visible flag, screen x and y
//   config    cfg_valid, cfg_ready, cfg_index  one camera register write
//             cfg_data
//
// one point per cycle sustained while results are popped; the back end is built around
// the 26-stage restoring divider
// the front end never stalls; a credit count on the 8-entry middle queue drives full
// the back end advances whenever its output register is empty or popped
// rst is synchronous and returns the camera registers to an identity view
module perspective_world_to_screen_core #(
  parameter int HALF_WIDTH  = 1080,
  parameter int HALF_HEIGHT = 1200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  pwts_pkg::point_t   point,
  output logic               empty,
  input  logic               pop,
  output pwts_pkg::result_t  result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pwts_pkg::*;

  cfg_t cfg;

  // camera registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x            <= '0;
      cfg.cam_y            <= '0;
      cfg.cam_z            <= '0;
      cfg.sin_pitch        <= '0;
      cfg.cos_pitch        <= 16'sd16384;
      cfg.sin_yaw          <= '0;
      cfg.cos_yaw          <= 16'sd16384;
      cfg.inv_half_fov_tan <= INV_W'(65536);
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_CAM_X:     cfg.cam_x            <= cfg_data;
        REG_CAM_Y:     cfg.cam_y            <= cfg_data;
        REG_CAM_Z:     cfg.cam_z            <= cfg_data;
        REG_SIN_PITCH: cfg.sin_pitch        <= cfg_data[15:0];
        REG_COS_PITCH: cfg.cos_pitch        <= cfg_data[15:0];
        REG_SIN_YAW:   cfg.sin_yaw          <= cfg_data[15:0];
        REG_COS_YAW:   cfg.cos_yaw          <= cfg_data[15:0];
        REG_INV_TAN:   cfg.inv_half_fov_tan <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  logic accept, mid_valid, q_empty, q_rd, back_en, out_valid;
  mid_t mid, q_data;
  logic [QC_W-1:0] credits;

  assign accept  = push & ~full;
  assign back_en = ~out_valid | pop;
  assign q_rd    = back_en & ~q_empty;
  assign empty   = ~out_valid;

  // items in the front end or the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + QC_W'(accept) - QC_W'(q_rd);
    end
  end
  assign full = (credits == QC_W'(QUEUE_DEPTH));

  pwts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .point     (point),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  pwts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_valid),
    .wr_data (mid),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  pwts_back #(
    .HALF_WIDTH  (HALF_WIDTH),
    .HALF_HEIGHT (HALF_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (back_en),
    .in_valid  (q_rd),
    .mid       (q_data),
    .inv_tan   (cfg.inv_half_fov_tan),
    .out_valid (out_valid),
    .result    (result)
  );

endmodule

[hdl/pwts_front.sv]
// front end: camera offset, view-axis dot products and depth classification
module pwts_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  pwts_pkg::point_t point,
  input  pwts_pkg::cfg_t   cfg,
  output logic            mid_valid,
  output pwts_pkg::mid_t   mid
);
  import pwts_pkg::*;

  // axis coefficients from the loaded trig values
  logic signed [31:0] cycp, sycp, spcy, spsy;
  logic signed [C_W-1:0] fx_c, fy_c, ux_c, uy_c, nsy_c;
  always_comb begin
    cycp  = cfg.cos_yaw * cfg.cos_pitch;
    sycp  = cfg.sin_yaw * cfg.cos_pitch;
    spcy  = cfg.sin_pitch * cfg.cos_yaw;
    spsy  = cfg.sin_pitch * cfg.sin_yaw;
    fx_c  = C_W'(cycp >>> 14);
    fy_c  = C_W'(sycp >>> 14);
    ux_c  = -C_W'(spcy >>> 14);
    uy_c  = -C_W'(spsy >>> 14);
    nsy_c = -C_W'(cfg.sin_yaw);
  end

  // stage 0: offsets and coefficients
  logic v0;
  logic signed [D_W-1:0] dx, dy, dz;
  logic signed [C_W-1:0] fx, fy, ux, uy, nsy, cy, sp, cp;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    dx  <= D_W'(point.point_x) - D_W'(cfg.cam_x);
    dy  <= D_W'(point.point_y) - D_W'(cfg.cam_y);
    dz  <= D_W'(point.point_z) - D_W'(cfg.cam_z);
    fx  <= fx_c;
    fy  <= fy_c;
    ux  <= ux_c;
    uy  <= uy_c;
    nsy <= nsy_c;
    cy  <= C_W'(cfg.cos_yaw);
    sp  <= C_W'(cfg.sin_pitch);
    cp  <= C_W'(cfg.cos_pitch);
  end

  // stage 1: dot-product terms
  logic v1;
  logic signed [P_W-1:0] t_dfx, t_dfy, t_dfz, t_rx, t_ry, t_ux, t_uy, t_uz;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    t_dfx <= dx * fx;
    t_dfy <= dy * fy;
    t_dfz <= dz * sp;
    t_rx  <= dx * nsy;
    t_ry  <= dy * cy;
    t_ux  <= dx * ux;
    t_uy  <= dy * uy;
    t_uz  <= dz * cp;
  end

  // sums, threshold and drop to Q.10
  logic signed [ACC_W-1:0] depth22, right22, up22;
  always_comb begin
    depth22 = ACC_W'(t_dfx) + ACC_W'(t_dfy) + ACC_W'(t_dfz);
    right22 = ACC_W'(t_rx) + ACC_W'(t_ry);
    up22    = ACC_W'(t_ux) + ACC_W'(t_uy) + ACC_W'(t_uz);
    mid_valid   = v1;
    mid.visible = (depth22 >= DEPTH_MIN);
    mid.depth10 = depth22[DEP_W+11:12];
    mid.right10 = right22[ACC_W-1:12];
    mid.up10    = up22[ACC_W-1:12];
  end

endmodule

[hdl/pwts_queue.sv]
// short queue between front and back ends
module pwts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  pwts_pkg::mid_t wr_data,
  input  logic           rd_en,
  output pwts_pkg::mid_t rd_data,
  output logic           empty
);
  import pwts_pkg::*;

  mid_t mem [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QC_W-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QC_W'(wr_en) - QC_W'(rd_en);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

endmodule

[hdl/pwts_back.sv]
// back end: fov scaling, pipelined restoring divide, viewport map and clamp
module pwts_back #(
  parameter int HALF_WIDTH  = 1080,
  parameter int HALF_HEIGHT = 1200
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  pwts_pkg::mid_t     mid,
  input  logic [pwts_pkg::INV_W-1:0] inv_tan,
  output logic               out_valid,
  output pwts_pkg::result_t  result
);
  import pwts_pkg::*;

  localparam logic signed [HS_W-1:0] GX = HS_W'(HALF_WIDTH * 16);
  localparam logic signed [HS_W-1:0] GY = HS_W'(HALF_HEIGHT * 16);

  // stage a: scale by inverse tangent
  logic va, vis_a;
  logic [DEP_W-1:0] dep_a;
  logic signed [M_W-1:0] mx, my;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      vis_a <= mid.visible;
      dep_a <= mid.depth10;
      mx    <= mid.right10 * $signed({1'b0, inv_tan});
      my    <= mid.up10 * $signed({1'b0, inv_tan});
    end
  end

  // stage b: viewport gain
  logic vb, vis_b;
  logic [DEP_W-1:0] dep_b;
  logic signed [N_W-1:0] nx, ny;
  logic signed [RX_W-1:0] rx, ry;
  assign rx = mx[M_W-1:16];
  assign ry = my[M_W-1:16];
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      vis_b <= vis_a;
      dep_b <= dep_a;
      nx    <= rx * GX;
      ny    <= ry * GY;
    end
  end

  // stage c: sign, magnitude and overflow check
  logic [N_W-1:0] dshift;
  logic [N_W-1:0] magx_c, magy_c;
  assign dshift = N_W'(dep_b) << QB;
  assign magx_c = nx[N_W-1] ? N_W'(-nx) : N_W'(nx);
  assign magy_c = ny[N_W-1] ? N_W'(-ny) : N_W'(ny);

  logic            v_d   [QB+1];
  logic            vis_d [QB+1];
  logic            negx_d[QB+1], negy_d[QB+1];
  logic            ovfx_d[QB+1], ovfy_d[QB+1];
  logic [DEP_W-1:0] dep_d [QB+1];
  logic [N_W-1:0]  remx_d[QB+1], remy_d[QB+1];
  logic [QB-1:0]   qx_d  [QB+1], qy_d  [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d[0] <= 1'b0;
    end else if (en) begin
      v_d[0] <= vb;
    end
    if (en) begin
      vis_d[0]  <= vis_b;
      negx_d[0] <= nx[N_W-1];
      negy_d[0] <= ny[N_W-1];
      ovfx_d[0] <= (magx_c >= dshift);
      ovfy_d[0] <= (magy_c >= dshift);
      dep_d[0]  <= dep_b;
      remx_d[0] <= magx_c;
      remy_d[0] <= magy_c;
      qx_d[0]   <= '0;
      qy_d[0]   <= '0;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [N_W-1:0] sub;
    logic           gx, gy;
    assign sub = N_W'(dep_d[s]) << (QB - 1 - s);
    assign gx  = (remx_d[s] >= sub);
    assign gy  = (remy_d[s] >= sub);
    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[s+1] <= 1'b0;
      end else if (en) begin
        v_d[s+1] <= v_d[s];
      end
      if (en) begin
        vis_d[s+1]  <= vis_d[s];
        negx_d[s+1] <= negx_d[s];
        negy_d[s+1] <= negy_d[s];
        ovfx_d[s+1] <= ovfx_d[s];
        ovfy_d[s+1] <= ovfy_d[s];
        dep_d[s+1]  <= dep_d[s];
        remx_d[s+1] <= gx ? remx_d[s] - sub : remx_d[s];
        remy_d[s+1] <= gy ? remy_d[s] - sub : remy_d[s];
        qx_d[s+1]   <= {qx_d[s][QB-2:0], gx};
        qy_d[s+1]   <= {qy_d[s][QB-2:0], gy};
      end
    end
  end

  // sign, offset and clamp; the visibility mask is applied in the output register
  logic signed [S_W-1:0] qxs, qys, sx, sy;
  logic signed [OUT_W-1:0] scx, scy;
  always_comb begin
    qxs = negx_d[QB] ? -$signed({2'b00, qx_d[QB]}) : $signed({2'b00, qx_d[QB]});
    qys = negy_d[QB] ? -$signed({2'b00, qy_d[QB]}) : $signed({2'b00, qy_d[QB]});
    sx  = S_W'(GX) + qxs;
    sy  = S_W'(GY) - qys;
    if (ovfx_d[QB]) begin
      scx = negx_d[QB] ? OUT_MIN[OUT_W-1:0] : OUT_MAX[OUT_W-1:0];
    end else if (sx > OUT_MAX) begin
      scx = OUT_MAX[OUT_W-1:0];
    end else if (sx < OUT_MIN) begin
      scx = OUT_MIN[OUT_W-1:0];
    end else begin
      scx = sx[OUT_W-1:0];
    end
    if (ovfy_d[QB]) begin
      scy = negy_d[QB] ? OUT_MAX[OUT_W-1:0] : OUT_MIN[OUT_W-1:0];
    end else if (sy > OUT_MAX) begin
      scy = OUT_MAX[OUT_W-1:0];
    end else if (sy < OUT_MIN) begin
      scy = OUT_MIN[OUT_W-1:0];
    end else begin
      scy = sy[OUT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_d[QB];
    end
    if (en) begin
      result.visible  <= vis_d[QB];
      result.screen_x <= vis_d[QB] ? scx : '0;
      result.screen_y <= vis_d[QB] ? scy : '0;
    end
  end

endmodule

[dv/tb_top.sv]
// self-checking testbench for the perspective world-to-screen core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pwts_pkg::*;

  localparam int  HW        = 1080;
  localparam int  HH        = 1200;
  localparam int  DRAIN_CYC = 48;  // drain wait through front end, queue and back end, with margin
  localparam longint DEPTH_THRESH = 4195;
  localparam longint SAT_HI = 8388607;
  localparam longint SAT_LO = -8388608;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  point_t     point = '0;
  logic       empty;
  logic       pop = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cfg_t    camera;           // predictor copy of the camera registers
  result_t screen_q[$];      // projections still to come out
  int      errors = 0;
  bit      no_idle = 1'b0;

  perspective_world_to_screen_core #(.HALF_WIDTH(HW), .HALF_HEIGHT(HH)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .point(point),
    .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // projection predictor
  function automatic result_t project(point_t p);
    longint dx, dy, dz, sp, cp, sy, cy, inv, fx, fy, ux, uy;
    longint depth22, right22, up22, depth10, rx, ry, qx, qy, sx, sy2;
    result_t r;
    dx = longint'(p.point_x) - longint'(camera.cam_x);
    dy = longint'(p.point_y) - longint'(camera.cam_y);
    dz = longint'(p.point_z) - longint'(camera.cam_z);
    sp = longint'(camera.sin_pitch);
    cp = longint'(camera.cos_pitch);
    sy = longint'(camera.sin_yaw);
    cy = longint'(camera.cos_yaw);
    inv = longint'({1'b0, camera.inv_half_fov_tan});
    fx = (cy * cp) >>> 14;
    fy = (sy * cp) >>> 14;
    ux = -((sp * cy) >>> 14);
    uy = -((sp * sy) >>> 14);
    depth22 = dx * fx + dy * fy + dz * sp;
    right22 = dx * (-sy) + dy * cy;
    up22 = dx * ux + dy * uy + dz * cp;
    r = '0;
    if (depth22 >= DEPTH_THRESH) begin
      depth10 = depth22 >>> 12;
      rx = ((right22 >>> 12) * inv) >>> 16;
      ry = ((up22 >>> 12) * inv) >>> 16;
      qx = (rx * (HW * 16)) / depth10;
      qy = (ry * (HH * 16)) / depth10;
      sx = HW * 16 + qx;
      sy2 = HH * 16 - qy;
      if (sx > SAT_HI) sx = SAT_HI;
      if (sx < SAT_LO) sx = SAT_LO;
      if (sy2 > SAT_HI) sy2 = SAT_HI;
      if (sy2 < SAT_LO) sy2 = SAT_LO;
      r.visible = 1'b1;
      r.screen_x = sx[23:0];
      r.screen_y = sy2[23:0];
    end
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 16);
  endfunction

  // result checker and pop driver
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (screen_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          errors++;
        end else begin
          want = screen_q.pop_front();
          if (result.visible !== want.visible) begin
            $display("%0t: visible expected %0b actual %0b", $time, want.visible,
                     result.visible);
            errors++;
          end
          if (result.screen_x !== want.screen_x) begin
            $display("%0t: screen_x expected %0d actual %0d", $time, want.screen_x,
                     result.screen_x);
            errors++;
          end
          if (result.screen_y !== want.screen_y) begin
            $display("%0t: screen_y expected %0d actual %0d", $time, want.screen_y,
                     result.screen_y);
            errors++;
          end
        end
      end
      pop <= !rst && !idle_now();
    end
  end

  // one point request
  task automatic send_point(point_t p);
    if (idle_now()) begin
      push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    push <= 1'b1;
    point <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    screen_q.push_back(project(p));
  endtask

  task automatic send_xyz(longint x, longint y, longint z);
    point_t p;
    p.point_x = x[31:0];
    p.point_y = y[31:0];
    p.point_z = z[31:0];
    send_point(p);
  endtask

  // drain the block before touching registers
  task automatic wait_idle();
    push <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // one register write request
  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAM_X:     camera.cam_x = data;
      REG_CAM_Y:     camera.cam_y = data;
      REG_CAM_Z:     camera.cam_z = data;
      REG_SIN_PITCH: camera.sin_pitch = data[15:0];
      REG_COS_PITCH: camera.cos_pitch = data[15:0];
      REG_SIN_YAW:   camera.sin_yaw = data[15:0];
      REG_COS_YAW:   camera.cos_yaw = data[15:0];
      REG_INV_TAN:   camera.inv_half_fov_tan = data[INV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_camera(cfg_t c);
    write_reg(REG_CAM_X, c.cam_x);
    write_reg(REG_CAM_Y, c.cam_y);
    write_reg(REG_CAM_Z, c.cam_z);
    write_reg(REG_SIN_PITCH, {16'($urandom_range(65535)), c.sin_pitch});
    write_reg(REG_COS_PITCH, {16'($urandom_range(65535)), c.cos_pitch});
    write_reg(REG_SIN_YAW, {16'($urandom_range(65535)), c.sin_yaw});
    write_reg(REG_COS_YAW, {16'($urandom_range(65535)), c.cos_yaw});
    write_reg(REG_INV_TAN, {9'($urandom), c.inv_half_fov_tan});
  endtask

  function automatic logic [15:0] rand_trig();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'sd16384;
    if (k == 1) return -16'sd16384;
    if (k == 2) return 16'($urandom);  // out of nominal range
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // corners of the point fields and some small points at the reset view
  task automatic test_reset_view();
    send_xyz(0, 0, 0);
    send_xyz(2147483647, 2147483647, 2147483647);
    send_xyz(-2147483648, -2147483648, -2147483648);
    send_xyz(2147483647, -2147483648, 2147483647);
    send_xyz(-2147483648, 2147483647, -2147483648);
    send_xyz(256, 0, 0);
    send_xyz(2560, 256, -256);
    send_xyz(-256, 100, 100);
    send_xyz(65536, -65536, 65536);
    wait_idle();
  endtask

  // depth right at and just below the visibility threshold
  task automatic test_depth_threshold();
    write_reg(REG_COS_PITCH, 32'd4195);
    send_xyz(1, 0, 0);
    send_xyz(1, 5, -5);
    send_xyz(0, 7, 7);
    wait_idle();
    write_reg(REG_COS_PITCH, 32'd4194);
    send_xyz(1, 0, 0);
    send_xyz(1, -3, 3);
    wait_idle();
    write_reg(REG_COS_PITCH, 32'd16384);
  endtask

  // near points far off axis clamp both screen coordinates; a zero inverse tangent centres one
  task automatic test_saturation();
    write_reg(REG_INV_TAN, 32'h7FFFFF);
    send_xyz(1, 2147483647, 2147483647);
    send_xyz(1, -2147483648, -2147483648);
    send_xyz(2, 100000000, -100000000);
    wait_idle();
    write_reg(REG_INV_TAN, 32'd0);
    send_xyz(1, 2147483647, -2147483648);
    wait_idle();
    write_reg(REG_INV_TAN, 32'd65536);
  endtask

  // writes to indexes past the register file change nothing
  task automatic test_bad_index();
    for (int i = 8; i < 16; i++) write_reg(4'(i), $urandom);
    send_xyz(1000, 300, -200);
    send_xyz(-5, 2147483647, 9);
    wait_idle();
  endtask

  // random cameras, extremes included, with random points
  task automatic test_random_cameras();
    cfg_t c;
    longint ox, oy, oz;
    for (int ph = 0; ph < 12; ph++) begin
      c.cam_x = $urandom;
      c.cam_y = $urandom;
      c.cam_z = $urandom;
      c.sin_pitch = rand_trig();
      c.cos_pitch = rand_trig();
      c.sin_yaw = rand_trig();
      c.cos_yaw = rand_trig();
      c.inv_half_fov_tan = (ph == 0) ? '0 : (ph == 1) ? '1 :
                           INV_W'($urandom_range(8388607));
      if (ph == 2) begin
        c.cam_x = 32'h7FFFFFFF;
        c.cam_y = 32'h80000000;
        c.cam_z = 32'h7FFFFFFF;
      end
      if (ph == 3) begin
        c.cam_x = 32'h80000000;
        c.cam_y = 32'h7FFFFFFF;
        c.cam_z = 32'h80000000;
      end
      if (ph < 6) c.inv_half_fov_tan = (ph < 2) ? c.inv_half_fov_tan :
                                       INV_W'($urandom_range(40000, 120000));
      load_camera(c);
      no_idle = (ph == 5);
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(9) < 7) begin
          ox = $signed($urandom_range(131072)) - 65536;
          oy = $signed($urandom_range(131072)) - 65536;
          oz = $signed($urandom_range(131072)) - 65536;
          send_xyz(longint'(camera.cam_x) + ox, longint'(camera.cam_y) + oy,
                   longint'(camera.cam_z) + oz);
        end else begin
          send_xyz(longint'($signed($urandom)), longint'($signed($urandom)),
                   longint'($signed($urandom)));
        end
        // sender holds off until the block has drained
        if (n == 60) begin
          push <= 1'b0;
          @(posedge clk);
          while (screen_q.size() != 0) @(posedge clk);
        end
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  // main sequence
  initial begin
    camera.cam_x = '0;
    camera.cam_y = '0;
    camera.cam_z = '0;
    camera.sin_pitch = '0;
    camera.cos_pitch = 16'sd16384;
    camera.sin_yaw = '0;
    camera.cos_yaw = 16'sd16384;
    camera.inv_half_fov_tan = INV_W'(65536);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (DRAIN_CYC) @(posedge clk);
    test_reset_view();
    test_depth_threshold();
    test_saturation();
    test_bad_index();
    test_random_cameras();
    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pwts_pkg.sv
hdl/pwts_front.sv
hdl/pwts_queue.sv
hdl/pwts_back.sv
hdl/perspective_world_to_screen_core.sv
dv/tb_top.sv
